// ----- sv/address_range_to_cidr_macros.svh -----
// Assertion helpers for the range-to-prefix block.
// Both sample on the rising edge of clk and are disabled while rst is high.
`ifndef ADDRESS_RANGE_TO_CIDR_MACROS_SVH
`define ADDRESS_RANGE_TO_CIDR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACIDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACIDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/acidr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package acidr_pkg;

  localparam int BASE_BITS   = 32;
  localparam int LEN_BITS    = 6;
  localparam int MAX_RESULTS = 62;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;       // load cursor and span from the incoming word
    logic size;        // register the size of the next prefix
    logic emit;        // load the output register and advance the cursor
    logic load_err;    // load the output register with the error word
    logic force_last;  // the result limit has been reached
  } acidr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;   // incoming range is inverted
    logic last;  // the sized prefix reaches the end of the range
  } acidr_stat_t;

endpackage

`default_nettype wire

// ----- sv/acidr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface acidr_range_if;
  logic        valid;
  logic        ready;
  logic [31:0] range_low;
  logic [31:0] range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink (input valid, input range_low, input range_high, output ready);
endinterface

interface acidr_prefix_if;
  logic        valid;
  logic        ready;
  logic [31:0] prefix_base;
  logic [5:0]  prefix_length;
  logic        last_prefix;
  logic        range_error;

  modport source (output valid, output prefix_base, output prefix_length,
                  output last_prefix, output range_error, input ready);
  modport sink (input valid, input prefix_base, input prefix_length,
                input last_prefix, input range_error, output ready);
endinterface

`default_nettype wire

// ----- sv/address_range_to_cidr.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "address_range_to_cidr_macros.svh"

// Splits an inclusive address range into the shortest ascending list of aligned
// prefixes that cover it exactly, one output word per prefix, with last_prefix
// set on the final one. An inverted range (low above high) leaves the block idle
// and yields a single word with range_error and last_prefix set. A valid range
// is split by the size-and-advance loop around the cursor register, which for
// each prefix first finds the largest aligned block and then emits it and steps
// past it, stalling while a word waits in the output register. A range yields
// at most 62 prefixes, and no new range is taken until its last prefix has been
// emitted. A new range is accepted only while the output register is empty or
// its word is taken in that same cycle.
module address_range_to_cidr #(
  parameter int ADDR_BITS = 32
) (
  input wire logic         clk,
  input wire logic         rst,
  acidr_range_if.sink      ranges,
  acidr_prefix_if.source   prefixes
);
  import acidr_pkg::*;

  acidr_cmd_t  cmd;
  acidr_stat_t stat;

  acidr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ranges.valid),
    .in_ready  (ranges.ready),
    .out_valid (prefixes.valid),
    .out_ready (prefixes.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  acidr_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .range_low     (ranges.range_low),
    .range_high    (ranges.range_high),
    .cmd           (cmd),
    .stat          (stat),
    .prefix_base   (prefixes.prefix_base),
    .prefix_length (prefixes.prefix_length),
    .last_prefix   (prefixes.last_prefix),
    .range_error   (prefixes.range_error)
  );

  `ACIDR_ASSERT_SAME(a_err_word, prefixes.valid && prefixes.range_error, prefixes.last_prefix && prefixes.prefix_length == 6'd0, "error word must be last and have zero length")
  `ACIDR_ASSERT_NEXT(a_err_follows, ranges.valid && ranges.ready && stat.err, prefixes.valid && prefixes.range_error, "inverted range did not produce an error word")
  `ACIDR_ASSERT_NEXT(a_busy_after_start, cmd.start, !ranges.ready, "new range accepted while one is in progress")
  `ACIDR_ASSERT_NEXT(a_continue, cmd.emit && !stat.last && !cmd.force_last, !ranges.ready && !cmd.emit, "range ended before its last prefix")

endmodule

`default_nettype wire

// ----- sv/acidr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module acidr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire acidr_pkg::acidr_stat_t stat,
  output acidr_pkg::acidr_cmd_t   cmd
);
  import acidr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SIZE = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic                out_valid_next;
  logic                out_hold;
  logic                in_fire;

  // The output register is free when empty or being drained this cycle.
  assign out_hold = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE) && !out_hold;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    count_next     = count;
    cmd            = '0;
    cmd.force_last = (count == CNT_BITS'(MAX_RESULTS - 1));
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (stat.err) begin
            cmd.load_err   = 1'b1;
            out_valid_next = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            count_next = '0;
            state_next = S_SIZE;
          end
        end
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_hold) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          count_next     = count + 1'b1;
          if (stat.last || cmd.force_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_SIZE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/acidr_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module acidr_dp #(
  parameter int ADDR_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic [31:0]            range_low,
  input  wire logic [31:0]            range_high,
  input  wire acidr_pkg::acidr_cmd_t  cmd,
  output acidr_pkg::acidr_stat_t      stat,
  output logic [31:0]                 prefix_base,
  output logic [5:0]                  prefix_length,
  output logic                        last_prefix,
  output logic                        range_error
);
  import acidr_pkg::*;

  localparam int KW = $clog2(ADDR_BITS + 1);
  localparam int LW = (KW > LEN_BITS) ? KW : LEN_BITS;

  logic [ADDR_BITS-1:0] lo, hi;
  logic [ADDR_BITS-1:0] cursor;
  // Number of addresses still to cover, which can be the whole space.
  logic [ADDR_BITS:0]   span;
  logic [KW-1:0]        best_k;
  logic [KW-1:0]        align_k, size_k;
  logic [ADDR_BITS:0]   blk;
  logic [ADDR_BITS-1:0] step;
  logic [LW-1:0]        len_full;

  assign lo = ADDR_BITS'(range_low);
  assign hi = ADDR_BITS'(range_high);

  // Alignment limit: trailing zeros of the cursor, the whole width at zero.
  always_comb begin
    align_k = KW'(ADDR_BITS);
    for (int i = ADDR_BITS - 1; i >= 0; i--) begin
      if (cursor[i]) align_k = KW'(i);
    end
  end

  // Size limit: position of the leading one of the remaining span.
  always_comb begin
    size_k = '0;
    for (int i = 0; i <= ADDR_BITS; i++) begin
      if (span[i]) size_k = KW'(i);
    end
  end

  assign blk      = (ADDR_BITS + 1)'(1) << best_k;
  assign step     = ADDR_BITS'(1) << best_k;
  assign len_full = LW'(ADDR_BITS) - LW'(best_k);

  assign stat.err  = lo > hi;
  assign stat.last = (span == blk);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cursor <= lo;
      span   <= {1'b0, hi} - {1'b0, lo} + (ADDR_BITS + 1)'(1);
    end
    if (cmd.size) begin
      best_k <= (align_k < size_k) ? align_k : size_k;
    end
    if (cmd.emit) begin
      prefix_base   <= BASE_BITS'(cursor);
      prefix_length <= len_full[LEN_BITS-1:0];
      last_prefix   <= stat.last || cmd.force_last;
      range_error   <= 1'b0;
      cursor        <= cursor + step;
      span          <= span - blk;
    end
    if (cmd.load_err) begin
      prefix_base   <= '0;
      prefix_length <= '0;
      last_prefix   <= 1'b1;
      range_error   <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_address_range_to_cidr.sv -----
`timescale 1ns / 1ps

module tb_address_range_to_cidr;
  import acidr_pkg::*;

  localparam int ADDR_W      = BASE_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_RANGES = 352;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [BASE_BITS-1:0] prefix_base;
    logic [LEN_BITS-1:0]  prefix_length;
    logic                 last_prefix;
    logic                 range_error;
  } prefix_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic              typed;
    prefix_word_t      word;
  } range_row_t;

  logic clk = 1'b0;
  logic rst;

  acidr_range_if  range_ch ();
  acidr_prefix_if prefix_ch ();

  address_range_to_cidr dut (
    .clk      (clk),
    .rst      (rst),
    .ranges   (range_ch),
    .prefixes (prefix_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  prefix_word_t expected_prefixes [$];
  int unsigned  mismatches       = 0;
  int unsigned  ranges_sent      = 0;
  int unsigned  inverted_sent    = 0;
  int unsigned  prefixes_checked = 0;
  bit           steady_tx        = 1'b0;
  bit           steady_rx        = 1'b0;
  bit           hold_req         = 1'b0;
  bit           hold_served      = 1'b0;
  int unsigned  hold_left        = 0;

  // Rows with a typed word give one prefix whose value is plain from the range;
  // the rest are expanded by the predictor.
  range_row_t directed_rows [0:17] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd32, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 6'd0,  1'b1, 1'b0}},
    '{32'h0000_0001, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0,  1'b1, 1'b1}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 6'd0,  1'b1, 1'b1}},
    '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 6'd1,  1'b1, 1'b0}},
    '{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 6'd1,  1'b1, 1'b0}},
    '{32'h0A00_0000, 32'h0AFF_FFFF, 1'b1, '{32'h0A00_0000, 6'd8,  1'b1, 1'b0}},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFE, 6'd31, 1'b1, 1'b0}},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 6'd0,  1'b1, 1'b1}},
    '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, '{32'h0000_0000, 6'd0,  1'b1, 1'b1}},
    '{32'h0000_0001, 32'hFFFF_FFFE, 1'b0, '0},
    '{32'h0000_0000, 32'hFFFF_FFFE, 1'b0, '0},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'hC0A8_0001, 32'hC0A8_00FE, 1'b0, '0},
    '{32'h0000_000A, 32'h0000_0014, 1'b0, '0},
    '{32'h0000_0001, 32'h0000_0002, 1'b0, '0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0}
  };

  // Expands one range into its covering prefixes, lowest first.
  function automatic void split_range(input logic [ADDR_W-1:0] lo,
                                      input logic [ADDR_W-1:0] hi);
    logic [ADDR_W:0] cur;
    logic [ADDR_W:0] top;
    logic [ADDR_W:0] mask;
    logic [ADDR_W:0] grow;
    int unsigned     fixed;
    int unsigned     count;
    bit              done;
    prefix_word_t    w;
    if (lo > hi) begin
      w = '{prefix_base: '0, prefix_length: '0, last_prefix: 1'b1, range_error: 1'b1};
      expected_prefixes.push_back(w);
      return;
    end
    cur   = {1'b0, lo};
    top   = {1'b0, hi};
    count = 0;
    done  = 1'b0;
    while (!done) begin
      mask  = '0;
      grow  = '0;
      fixed = 0;
      // Widen the block while its base stays aligned and its end stays in range.
      for (int k = 1; k <= ADDR_W; k++) begin
        grow = (grow << 1) | 1;
        if ((cur & grow) != 0 || (cur | grow) > top) break;
        mask  = grow;
        fixed = k;
      end
      done = ((cur | mask) == top) || (count + 1 >= MAX_RESULTS);
      w.prefix_base   = cur[ADDR_W-1:0];
      w.prefix_length = LEN_BITS'(ADDR_W - fixed);
      w.last_prefix   = done;
      w.range_error   = 1'b0;
      expected_prefixes.push_back(w);
      count++;
      cur = {1'b0, ADDR_W'((cur | mask) + 1)};
    end
  endfunction

  task automatic report_mismatch(input string why, input prefix_word_t want,
                                 input prefix_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %h/%0d last %0b err %0b, got %h/%0d last %0b err %0b",
               $realtime, why, want.prefix_base, want.prefix_length, want.last_prefix,
               want.range_error, got.prefix_base, got.prefix_length, got.last_prefix,
               got.range_error);
  endtask

  task automatic send_range(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                            input logic typed, input prefix_word_t word);
    if (!steady_tx) begin
      while ($urandom_range(99) < 35) begin
        range_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    range_ch.valid      <= 1'b1;
    range_ch.range_low  <= lo;
    range_ch.range_high <= hi;
    @(posedge clk);
    while (!range_ch.ready) @(posedge clk);
    ranges_sent++;
    if (lo > hi) inverted_sent++;
    if (typed) expected_prefixes.push_back(word);
    else split_range(lo, hi);
  endtask

  // Holds the sender back until every outstanding prefix has been taken.
  task automatic drain_prefixes();
    range_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_prefixes.size() != 0);
  endtask

  task automatic pick_range(output logic [ADDR_W-1:0] lo, output logic [ADDR_W-1:0] hi);
    int unsigned  kind;
    int unsigned  k;
    logic [63:0]  size;
    logic [63:0]  base;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    kind = $urandom_range(99);
    a = $urandom;
    b = $urandom;
    if (kind < 10) begin
      lo = (a == 0) ? 32'h1 : a;
      hi = b % lo;
    end else if (kind < 35) begin
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
    end else if (kind < 60) begin
      size = {32'h0, a} + $urandom_range(300);
      lo = a;
      hi = (size > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : size[ADDR_W-1:0];
    end else if (kind < 75) begin
      k    = $urandom_range(ADDR_W);
      size = 64'h1 << k;
      base = {32'h0, a} & ~(size - 1);
      lo   = base[ADDR_W-1:0];
      hi   = ADDR_W'(base + size - 1);
    end else if (kind < 85) begin
      lo = a;
      hi = a;
    end else begin
      // Nearly aligned ranges: ragged ends around a large block.
      k    = $urandom_range(ADDR_W, 2);
      size = 64'h1 << k;
      base = {32'h0, a} & ~(size - 1);
      lo   = ADDR_W'(base + $urandom_range(3));
      hi   = ADDR_W'(base + size - 1 - $urandom_range(3));
    end
  endtask

  always @(posedge clk) begin
    if (hold_req && !hold_served) begin
      hold_left   = HOLD_CYCLES;
      hold_served = 1'b1;
    end
    if (rst) begin
      prefix_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      prefix_ch.ready <= 1'b0;
    end else if (steady_rx) begin
      prefix_ch.ready <= 1'b1;
    end else begin
      prefix_ch.ready <= ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk) begin
    prefix_word_t got;
    prefix_word_t want;
    if (!rst && prefix_ch.valid && prefix_ch.ready) begin
      got = '{prefix_ch.prefix_base, prefix_ch.prefix_length, prefix_ch.last_prefix,
              prefix_ch.range_error};
      if (expected_prefixes.size() == 0) begin
        report_mismatch("unexpected word", '0, got);
      end else begin
        want = expected_prefixes.pop_front();
        prefixes_checked++;
        if (got.prefix_base !== want.prefix_base ||
            got.prefix_length !== want.prefix_length ||
            got.last_prefix !== want.last_prefix ||
            got.range_error !== want.range_error)
          report_mismatch("word mismatch", want, got);
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(negedge rst);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((range_ch.valid && range_ch.ready) || (prefix_ch.valid && prefix_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("tb_address_range_to_cidr NOT OK");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    rst                 = 1'b1;
    range_ch.valid      = 1'b0;
    range_ch.range_low  = '0;
    range_ch.range_high = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_range(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].typed,
                 directed_rows[i].word);
    drain_prefixes();

    for (int n = 0; n < RANDOM_RANGES; n++) begin
      // The receiver stops for a long while as the sender keeps offering ranges.
      if (n == 60) begin
        hold_req  = 1'b1;
        steady_tx = 1'b1;
      end
      if (n == 90) steady_tx = 1'b0;
      if (n == 130) drain_prefixes();
      if (n == 180) begin
        steady_tx = 1'b1;
        steady_rx = 1'b1;
      end
      if (n == 240) begin
        steady_tx = 1'b0;
        steady_rx = 1'b0;
      end
      pick_range(lo, hi);
      send_range(lo, hi, 1'b0, '0);
    end
    range_ch.valid <= 1'b0;

    while (expected_prefixes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += expected_prefixes.size();

    $display("Sent %0d ranges (%0d inverted), checked %0d prefixes, %0d mismatches.",
             ranges_sent, inverted_sent, prefixes_checked, mismatches);
    if (mismatches == 0)
      $display("tb_address_range_to_cidr OK");
    else
      $display("tb_address_range_to_cidr NOT OK");
    $finish;
  end

endmodule
